// ===== rtl/sace_pkg.sv =====
// ----------------------------------------------------------------------------
// sace_pkg: shared types and constants for the size-aware eviction cache
// Request and response beats, scan token, slot write command, codes.
// ----------------------------------------------------------------------------
package sace_pkg;

   localparam logic [23:0] CAPACITY_RESET = 24'(10 * 1024 * 1024);
   localparam logic [23:0] MAX_ITEM_RESET = 24'(500 * 1024);
   localparam int          KB_SHIFT       = 10;

   localparam int          CSR_IDX_W      = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_CAPACITY = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_ITEM = 2'd1;

   typedef enum logic [2:0] {
      ST_EVICTED  = 3'd0,
      ST_HIT      = 3'd1,
      ST_INSERTED = 3'd2,
      ST_TOO_BIG  = 3'd3,
      ST_NO_ROOM  = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      FSM_IDLE,
      FSM_SCAN,
      FSM_DECIDE
   } fsm_type;

   typedef enum logic [1:0] {
      WR_NONE,
      WR_TIME,
      WR_ENTRY
   } wr_op_type;

   typedef struct packed {
      logic [31:0] item_id;
      logic [23:0] item_bytes;
      logic [31:0] time_now;
   } req_type;

   typedef struct packed {
      status_type  status;
      logic [31:0] evicted_id;
      logic [23:0] evicted_bytes;
      logic        last;
   } rsp_type;

   typedef struct packed {
      logic [31:0] id;
      logic [31:0] stamp;
      logic [23:0] bytes;
   } entry_type;

   typedef struct packed {
      wr_op_type op;
      entry_type data;
   } wr_type;

   // running result handed from cell to cell
   typedef struct packed {
      logic               found;
      logic signed [23:0] score;
      logic [31:0]        id;
      logic [23:0]        bytes;
      logic               hit;
   } token_type;

endpackage

// ===== rtl/size_aware_cache_eviction.sv =====
// ----------------------------------------------------------------------------
// size_aware_cache_eviction: slot cache with size-aware victim selection
// Looks up an item, refreshes it on a hit, otherwise evicts by score until
// the item fits, then inserts it; refuses items too big or that cannot fit.
// ----------------------------------------------------------------------------
//  channel  | ports                              | beat taken when
//  ---------+------------------------------------+------------------------
//  request  | start, busy, req_item              | start && !busy
//  response | rsp_strobe, rsp_data               | rsp_strobe (no stall)
//  config   | csr_valid, csr_ready, csr_index,   | csr_valid && csr_ready
//           | csr_wdata                          |
//
// Flow: a too-large request is answered by one registered beat and leaves
// busy low. Any other request runs a scan down the row of ENTRIES cells
// (one cell per cycle) followed by a decide state; each eviction adds
// another scan and decide.
// Reset clears the fill count and the byte total and loads the config registers
// with their reset values; slot contents stay undefined and are never read beyond the fill count.
// The response side cannot stall: each beat shows for one cycle.
// ----------------------------------------------------------------------------
module size_aware_cache_eviction #(
   parameter int ENTRIES = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  sace_pkg::req_type                 req_item,
   output logic                              rsp_strobe,
   output sace_pkg::rsp_type                 rsp_data,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [sace_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [23:0]                       csr_wdata
);

   localparam int IDX_W = $clog2(ENTRIES);
   localparam int CNT_W = $clog2(ENTRIES + 1);

   sace_pkg::fsm_type    state_ff, state_in;
   logic [IDX_W-1:0]     scan_cnt_ff, scan_cnt_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic [23:0]          used_ff, used_in;
   logic [23:0]          cap_ff, max_ff;
   sace_pkg::req_type    req_ff;
   logic                 rsp_strobe_ff, rsp_strobe_in;
   sace_pkg::rsp_type    rsp_ff, rsp_in;

   sace_pkg::wr_type     wr;
   logic [IDX_W-1:0]     wr_idx;

   sace_pkg::token_type  tok_chain [ENTRIES+1];
   logic [IDX_W-1:0]     hit_chain [ENTRIES+1];
   logic [IDX_W-1:0]     vic_chain [ENTRIES+1];
   sace_pkg::entry_type  entries   [ENTRIES];

   sace_pkg::token_type  tok_end;
   sace_pkg::entry_type  last_entry;
   logic [IDX_W-1:0]     last_idx;
   logic                 accept;
   logic                 too_big;
   logic                 need_room;

   assign accept    = start && !busy;
   assign too_big   = req_item.item_bytes > max_ff;
   assign busy      = (state_ff != sace_pkg::FSM_IDLE);
   assign csr_ready = 1'b1;
   assign tok_end   = tok_chain[ENTRIES];
   assign last_idx  = IDX_W'(count_ff - 1'b1);
   assign last_entry = entries[last_idx];

   // evict while the item overflows the budget or every slot is taken
   assign need_room = ({1'b0, used_ff} + {1'b0, req_ff.item_bytes} > {1'b0, cap_ff})
                   || (count_ff >= CNT_W'(ENTRIES));

   // seed the chain with an empty token
   assign tok_chain[0] = '0;
   assign hit_chain[0] = '0;
   assign vic_chain[0] = '0;

   for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
      sace_cell #(
         .ENTRIES  (ENTRIES),
         .CELL_IDX (g)
      ) u_cell (
         .clock     (clock),
         .req_i     (req_ff),
         .count_i   (count_ff),
         .wr_i      (wr),
         .wr_idx_i  (wr_idx),
         .tok_i     (tok_chain[g]),
         .hit_idx_i (hit_chain[g]),
         .vic_idx_i (vic_chain[g]),
         .tok_o     (tok_chain[g+1]),
         .hit_idx_o (hit_chain[g+1]),
         .vic_idx_o (vic_chain[g+1]),
         .entry_o   (entries[g])
      );
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         sace_pkg::FSM_IDLE: begin
            if (accept && !too_big) begin
               state_in = sace_pkg::FSM_SCAN;
            end
         end
         sace_pkg::FSM_SCAN: begin
            if (scan_cnt_ff == IDX_W'(ENTRIES - 1)) begin
               state_in = sace_pkg::FSM_DECIDE;
            end
         end
         sace_pkg::FSM_DECIDE: begin
            if (!tok_end.hit && need_room && count_ff != '0) begin
               state_in = sace_pkg::FSM_SCAN;
            end else begin
               state_in = sace_pkg::FSM_IDLE;
            end
         end
         default: state_in = sace_pkg::FSM_IDLE;
      endcase
   end

   // outputs and datapath
   always_comb begin
      scan_cnt_in   = '0;
      count_in      = count_ff;
      used_in       = used_ff;
      rsp_strobe_in = 1'b0;
      rsp_in        = '0;
      wr            = '0;
      wr_idx        = '0;
      case (state_ff)
         sace_pkg::FSM_IDLE: begin
            if (accept && too_big) begin
               rsp_strobe_in = 1'b1;
               rsp_in.status = sace_pkg::ST_TOO_BIG;
               rsp_in.last   = 1'b1;
            end
         end
         sace_pkg::FSM_SCAN: begin
            scan_cnt_in = scan_cnt_ff + 1'b1;
         end
         sace_pkg::FSM_DECIDE: begin
            rsp_strobe_in = 1'b1;
            if (tok_end.hit) begin
               // refresh the stamp of the held entry
               wr.op         = sace_pkg::WR_TIME;
               wr.data.stamp = req_ff.time_now;
               wr_idx        = hit_chain[ENTRIES];
               rsp_in.status = sace_pkg::ST_HIT;
               rsp_in.last   = 1'b1;
            end else if (need_room && count_ff == '0) begin
               rsp_in.status = sace_pkg::ST_NO_ROOM;
               rsp_in.last   = 1'b1;
            end else if (need_room) begin
               // drop the victim, fill its slot from the last one
               rsp_in.status        = sace_pkg::ST_EVICTED;
               rsp_in.evicted_id    = tok_end.id;
               rsp_in.evicted_bytes = tok_end.bytes;
               wr.op                = sace_pkg::WR_ENTRY;
               wr.data              = last_entry;
               wr_idx               = vic_chain[ENTRIES];
               count_in             = count_ff - 1'b1;
               used_in              = used_ff - tok_end.bytes;
            end else begin
               wr.op         = sace_pkg::WR_ENTRY;
               wr.data.id    = req_ff.item_id;
               wr.data.stamp = req_ff.time_now;
               wr.data.bytes = req_ff.item_bytes;
               wr_idx        = IDX_W'(count_ff);
               count_in      = count_ff + 1'b1;
               used_in       = used_ff + req_ff.item_bytes;
               rsp_in.status = sace_pkg::ST_INSERTED;
               rsp_in.last   = 1'b1;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= sace_pkg::FSM_IDLE;
         scan_cnt_ff   <= '0;
         count_ff      <= '0;
         used_ff       <= '0;
         cap_ff        <= sace_pkg::CAPACITY_RESET;
         max_ff        <= sace_pkg::MAX_ITEM_RESET;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         scan_cnt_ff   <= scan_cnt_in;
         count_ff      <= count_in;
         used_ff       <= used_in;
         rsp_strobe_ff <= rsp_strobe_in;
         if (csr_valid && csr_ready) begin
            case (csr_index)
               sace_pkg::CSR_CAPACITY: cap_ff <= csr_wdata;
               sace_pkg::CSR_MAX_ITEM: max_ff <= csr_wdata;
               default: ;
            endcase
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
      if (accept) begin
         req_ff <= req_item;
      end
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;

   // ------------------------------------------------------------------
   // assertions
   // ------------------------------------------------------------------
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(ENTRIES))
      else $error("fill count beyond slot total");

   a_evict_then_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_data.last |-> busy)
      else $error("non-final beat while idle");

   a_too_big: assert property (@(posedge clock) disable iff (reset)
      accept && too_big |=> rsp_strobe && rsp_data.status == sace_pkg::ST_TOO_BIG)
      else $error("oversize request not refused");

   a_evict_count: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_data.status == sace_pkg::ST_EVICTED
      |-> count_ff == CNT_W'($past(count_ff) - 1'b1))
      else $error("eviction without slot release");

endmodule

// ===== rtl/sace_cell.sv =====
// ----------------------------------------------------------------------------
// sace_cell: one cache slot of the scan chain
// Holds one entry, scores it against the current request and forwards the
// best-so-far token, its slot index and the first hit to the next cell.
// ----------------------------------------------------------------------------
module sace_cell #(
   parameter int ENTRIES  = 16,
   parameter int CELL_IDX = 0,
   localparam int IDX_W   = $clog2(ENTRIES),
   localparam int CNT_W   = $clog2(ENTRIES + 1)
) (
   input  logic                  clock,
   input  sace_pkg::req_type     req_i,
   input  logic [CNT_W-1:0]      count_i,
   input  sace_pkg::wr_type      wr_i,
   input  logic [IDX_W-1:0]      wr_idx_i,
   input  sace_pkg::token_type   tok_i,
   input  logic [IDX_W-1:0]      hit_idx_i,
   input  logic [IDX_W-1:0]      vic_idx_i,
   output sace_pkg::token_type   tok_o,
   output logic [IDX_W-1:0]      hit_idx_o,
   output logic [IDX_W-1:0]      vic_idx_o,
   output sace_pkg::entry_type   entry_o
);

   localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);

   sace_pkg::entry_type  entry_ff;
   sace_pkg::token_type  tok_ff, tok_in;
   logic [IDX_W-1:0]     hit_idx_ff, hit_idx_in;
   logic [IDX_W-1:0]     vic_idx_ff, vic_idx_in;

   logic                 active;
   logic [31:0]          age;
   logic signed [31:0]   age_sh;
   logic signed [14:0]   delta;
   logic signed [16:0]   pen;
   logic signed [23:0]   score;

   assign active = (CNT_W'(CELL_IDX) < count_i);

   // score: age in 1024 ms units minus kilobyte gap, gap doubled when smaller
   always_comb begin
      age    = req_i.time_now - entry_ff.stamp;
      age_sh = $signed(age) >>> sace_pkg::KB_SHIFT;
      delta  = $signed({1'b0, entry_ff.bytes[23:sace_pkg::KB_SHIFT]})
             - $signed({1'b0, req_i.item_bytes[23:sace_pkg::KB_SHIFT]});
      if (delta[14]) begin
         pen = (17'sd0 - 17'(delta)) <<< 1;
      end else begin
         pen = 17'(delta);
      end
      score = 24'(age_sh) - 24'(pen);
   end

   always_comb begin
      tok_in     = tok_i;
      hit_idx_in = hit_idx_i;
      vic_idx_in = vic_idx_i;
      if (active) begin
         if (!tok_i.hit && entry_ff.id == req_i.item_id) begin
            tok_in.hit = 1'b1;
            hit_idx_in = MY_IDX;
         end
         if (!tok_i.found || score > tok_i.score) begin
            tok_in.found = 1'b1;
            tok_in.score = score;
            tok_in.id    = entry_ff.id;
            tok_in.bytes = entry_ff.bytes;
            vic_idx_in   = MY_IDX;
         end
      end
   end

   always_ff @(posedge clock) begin
      tok_ff     <= tok_in;
      hit_idx_ff <= hit_idx_in;
      vic_idx_ff <= vic_idx_in;
      if (wr_idx_i == MY_IDX) begin
         if (wr_i.op == sace_pkg::WR_TIME) begin
            entry_ff.stamp <= wr_i.data.stamp;
         end else if (wr_i.op == sace_pkg::WR_ENTRY) begin
            entry_ff <= wr_i.data;
         end
      end
   end

   assign tok_o     = tok_ff;
   assign hit_idx_o = hit_idx_ff;
   assign vic_idx_o = vic_idx_ff;
   assign entry_o   = entry_ff;

endmodule
